### rtl/cbd_pkg.sv
`timescale 1ns / 1ps

package cbd_pkg;

    localparam int SOURCE_WIDTH = 160;
    localparam int OUTPUT_SIZE  = 128;
    localparam int COL_W        = $clog2(SOURCE_WIDTH);
    localparam int PADDR_W      = 5;

    localparam logic [31:0] CH_MASK    = 32'h07E0_F81F;
    localparam logic [5:0]  WEIGHT_ONE = 6'd32;
    localparam logic [7:0]  ROW_MAX    = 8'd255;
    localparam logic [5:0]  CROP_X_MAX = 6'd32;
    localparam logic [4:0]  CROP_Y_MAX = 5'd16;

    // horizontal weight by output column mod 4, vertical by output row mod 8
    localparam logic [3:0][4:0] COL_WEIGHT = {5'd26, 5'd19, 5'd13, 5'd6};
    localparam logic [7:0][4:0] ROW_WEIGHT = {5'd28, 5'd25, 5'd21, 5'd18,
                                              5'd14, 5'd11, 5'd7, 5'd4};

    typedef enum logic [1:0] {
        MODE_NEAREST = 2'd0,
        MODE_RGB     = 2'd1,
        MODE_PALETTE = 2'd2,
        MODE_CROP    = 2'd3
    } mode_t;

    typedef enum logic [1:0] {
        KIND_PASS = 2'd0,
        KIND_RGB  = 2'd1,
        KIND_PAL  = 2'd2
    } kind_t;

    typedef enum logic [2:0] {
        REG_MODE     = 3'd0,
        REG_WINDOW_X = 3'd1,
        REG_WINDOW_Y = 3'd2,
        REG_SHADE0   = 3'd3,
        REG_SHADE1   = 3'd4,
        REG_SHADE2   = 3'd5,
        REG_SHADE3   = 3'd6
    } reg_idx_t;

    typedef struct packed {
        logic [15:0] color;
        logic [1:0]  shade;
        logic        frame_start;
    } src_word_t;

    typedef struct packed {
        logic [15:0] pixel;
        logic [6:0]  out_x;
        logic [6:0]  out_y;
        logic        frame_end;
    } dst_word_t;

    typedef struct packed {
        mode_t       mode;
        logic [5:0]  window_x;
        logic [4:0]  window_y;
    } cfg_t;

    typedef logic [3:0][15:0] palette_t;

    typedef struct packed {
        kind_t       kind;
        logic [15:0] color;
        logic [1:0]  shade;
        logic [15:0] left_color;
        logic [1:0]  left_shade;
        logic [15:0] ul_color;
        logic [1:0]  ul_shade;
        logic [15:0] up_color;
        logic [1:0]  up_shade;
        logic [6:0]  dx;
        logic [6:0]  dy;
    } q_entry_t;

    function automatic logic [31:0] spread565(input logic [15:0] p);
        return {p, p} & CH_MASK;
    endfunction

    // lerp all three channels at once, guard bits absorb the borrows
    function automatic logic [31:0] mix565(input logic [31:0] a, input logic [31:0] b,
                                           input logic [4:0] w);
        logic [31:0] diff;
        logic [31:0] prod;
        diff = b - a;
        prod = diff * {27'd0, w};
        return (a + (prod >> 5)) & CH_MASK;
    endfunction

    function automatic logic [15:0] pack565(input logic [31:0] c);
        return c[15:0] | c[31:16];
    endfunction

endpackage

### rtl/cbd_ram.sv
`timescale 1ns / 1ps

module cbd_ram #(
    parameter int WIDTH = 18,
    parameter int DEPTH = 160
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

### rtl/cbd_front.sv
`timescale 1ns / 1ps

module cbd_front (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               src_valid,
    output logic               src_stall,
    input  cbd_pkg::src_word_t src_word,
    input  cbd_pkg::cfg_t      cfg,
    input  logic               q_full,
    output logic               push,
    output cbd_pkg::q_entry_t  push_entry
);

    import cbd_pkg::*;

    localparam logic [2:0] COL_PHASE_LAST = 3'd4;
    localparam logic [3:0] ROW_PHASE_LAST = 4'd8;
    localparam logic [4:0] ROW_K_LIMIT    = 5'(OUTPUT_SIZE / 8);

    logic accept;
    logic busy_reg;

    // source position, plus its split into (k, phase) for the 5:4 and 9:8 picks
    logic [COL_W-1:0] col_reg, col_eff, col_next;
    logic [2:0]       col_m5_reg, m5_eff, col_m5_next;
    logic [4:0]       col_k_reg, ck_eff, col_k_next;
    logic [7:0]       row_reg, row_eff, row_next;
    logic [3:0]       row_m9_reg, m9_eff, row_m9_next;
    logic [4:0]       row_k_reg, rk_eff, row_k_next;
    logic             row_adv;
    logic [3:0]       prow_m9_reg;
    logic [4:0]       prow_k_reg;
    logic             pcol_ok_reg;
    logic [6:0]       pcol_dx_reg;

    logic       ncol_ok, nrow_ok, prow_ok;
    logic [6:0] ncol_dx, nrow_dy, prow_dy;
    logic [5:0] crop_x;
    logic [4:0] crop_y;
    logic [7:0] crop_dc, crop_dr;
    logic       crop_col_ok, crop_row_ok;

    logic       emit;
    kind_t      kind;
    logic [6:0] dx, dy;

    logic [15:0]      cap_color_reg;
    logic [1:0]       cap_shade_reg;
    logic [COL_W-1:0] cap_col_reg;
    logic             cap_emit_reg;
    kind_t            cap_kind_reg;
    logic [6:0]       cap_dx_reg, cap_dy_reg;

    logic [15:0] left_color_reg, ul_color_reg;
    logic [1:0]  left_shade_reg, ul_shade_reg;
    logic [17:0] up_data;

    assign src_stall = busy_reg | q_full;
    assign accept    = src_valid & ~src_stall;

    always_comb
    begin
        col_eff = src_word.frame_start ? '0 : col_reg;
        m5_eff  = src_word.frame_start ? '0 : col_m5_reg;
        ck_eff  = src_word.frame_start ? '0 : col_k_reg;
        row_eff = src_word.frame_start ? '0 : row_reg;
        m9_eff  = src_word.frame_start ? '0 : row_m9_reg;
        rk_eff  = src_word.frame_start ? '0 : row_k_reg;
    end

    // column k never exceeds 31, so every mapped column lands below 128
    assign ncol_ok = m5_eff < COL_PHASE_LAST;
    assign ncol_dx = {ck_eff, m5_eff[1:0]};
    assign nrow_ok = (m9_eff < ROW_PHASE_LAST) && (rk_eff < ROW_K_LIMIT);
    assign nrow_dy = {rk_eff[3:0], m9_eff[2:0]};
    assign prow_ok = (prow_m9_reg < ROW_PHASE_LAST) && (prow_k_reg < ROW_K_LIMIT);
    assign prow_dy = {prow_k_reg[3:0], prow_m9_reg[2:0]};

    assign crop_x      = (cfg.window_x > CROP_X_MAX) ? CROP_X_MAX : cfg.window_x;
    assign crop_y      = (cfg.window_y > CROP_Y_MAX) ? CROP_Y_MAX : cfg.window_y;
    assign crop_dc     = col_eff - {2'b00, crop_x};
    assign crop_dr     = row_eff - {3'b000, crop_y};
    assign crop_col_ok = (col_eff >= {2'b00, crop_x}) && (crop_dc < 8'(OUTPUT_SIZE));
    assign crop_row_ok = (row_eff >= {3'b000, crop_y}) && (crop_dr < 8'(OUTPUT_SIZE));

    always_comb
    begin
        emit = 1'b0;
        kind = KIND_PASS;
        dx   = ncol_dx;
        dy   = nrow_dy;
        unique case (cfg.mode) inside
            MODE_NEAREST:
            begin
                emit = ncol_ok && nrow_ok;
            end
            MODE_CROP:
            begin
                emit = crop_col_ok && crop_row_ok;
                dx   = crop_dc[6:0];
                dy   = crop_dr[6:0];
            end
            MODE_RGB, MODE_PALETTE:
            begin
                // blend fires on the lower-right pixel of its 2x2 block
                emit = (col_eff != '0) && (row_eff != '0) && pcol_ok_reg && prow_ok;
                kind = (cfg.mode == MODE_RGB) ? KIND_RGB : KIND_PAL;
                dx   = pcol_dx_reg;
                dy   = prow_dy;
            end
            default:
            begin
                emit = 1'b0;
            end
        endcase
    end

    always_comb
    begin
        col_next    = col_eff + 1'b1;
        col_m5_next = (m5_eff == COL_PHASE_LAST) ? '0 : m5_eff + 1'b1;
        col_k_next  = ck_eff + {4'd0, (m5_eff == COL_PHASE_LAST)};
        row_next    = row_eff;
        row_m9_next = m9_eff;
        row_k_next  = rk_eff;
        row_adv     = 1'b0;
        if (col_eff == COL_W'(SOURCE_WIDTH - 1))
        begin
            col_next    = '0;
            col_m5_next = '0;
            col_k_next  = '0;
            // hold the row once it saturates
            if (row_eff != ROW_MAX)
            begin
                row_adv     = 1'b1;
                row_next    = row_eff + 1'b1;
                row_m9_next = (m9_eff == ROW_PHASE_LAST) ? '0 : m9_eff + 1'b1;
                row_k_next  = rk_eff + {4'd0, (m9_eff == ROW_PHASE_LAST)};
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg       <= 1'b0;
            col_reg        <= '0;
            col_m5_reg     <= '0;
            col_k_reg      <= '0;
            row_reg        <= '0;
            row_m9_reg     <= '0;
            row_k_reg      <= '0;
            prow_m9_reg    <= '0;
            prow_k_reg     <= '0;
            pcol_ok_reg    <= 1'b0;
            pcol_dx_reg    <= '0;
            left_color_reg <= '0;
            left_shade_reg <= '0;
            ul_color_reg   <= '0;
            ul_shade_reg   <= '0;
        end
        else
        begin
            busy_reg <= accept;
            if (accept)
            begin
                col_reg     <= col_next;
                col_m5_reg  <= col_m5_next;
                col_k_reg   <= col_k_next;
                row_reg     <= row_next;
                row_m9_reg  <= row_m9_next;
                row_k_reg   <= row_k_next;
                pcol_ok_reg <= ncol_ok;
                pcol_dx_reg <= ncol_dx;
                if (row_adv)
                begin
                    prow_m9_reg <= m9_eff;
                    prow_k_reg  <= rk_eff;
                end
            end
            if (busy_reg)
            begin
                left_color_reg <= cap_color_reg;
                left_shade_reg <= cap_shade_reg;
                ul_color_reg   <= up_data[17:2];
                ul_shade_reg   <= up_data[1:0];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            cap_color_reg <= src_word.color;
            cap_shade_reg <= src_word.shade;
            cap_col_reg   <= col_eff;
            cap_emit_reg  <= emit;
            cap_kind_reg  <= kind;
            cap_dx_reg    <= dx;
            cap_dy_reg    <= dy;
        end
    end

    // previous-row line buffer: read on accept, written back the cycle after
    cbd_ram #(
        .WIDTH(18),
        .DEPTH(SOURCE_WIDTH)
    ) u_line_buf (
        .clk     (clk),
        .wr_en   (busy_reg),
        .wr_addr (cap_col_reg),
        .wr_data ({cap_color_reg, cap_shade_reg}),
        .rd_en   (accept),
        .rd_addr (col_eff),
        .rd_data (up_data)
    );

    assign push = busy_reg & cap_emit_reg;

    always_comb
    begin
        push_entry.kind       = cap_kind_reg;
        push_entry.color      = cap_color_reg;
        push_entry.shade      = cap_shade_reg;
        push_entry.left_color = left_color_reg;
        push_entry.left_shade = left_shade_reg;
        push_entry.ul_color   = ul_color_reg;
        push_entry.ul_shade   = ul_shade_reg;
        push_entry.up_color   = up_data[17:2];
        push_entry.up_shade   = up_data[1:0];
        push_entry.dx         = cap_dx_reg;
        push_entry.dy         = cap_dy_reg;
    end

    a_push_follows_emit: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> (push == $past(emit)))
        else $error("front push does not match classification");

    a_col_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        (col_reg < COL_W'(SOURCE_WIDTH)) && (col_m5_reg <= COL_PHASE_LAST))
        else $error("column counter out of range");

endmodule

### rtl/cbd_queue.sv
`timescale 1ns / 1ps

module cbd_queue #(
    parameter int DEPTH = 4
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              push,
    input  cbd_pkg::q_entry_t push_entry,
    input  logic              pop,
    output cbd_pkg::q_entry_t head,
    output logic              empty,
    output logic              full
);

    import cbd_pkg::*;

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    q_entry_t        slot_reg [DEPTH];
    logic [PW-1:0]   wr_ptr_reg, rd_ptr_reg;
    logic [CW-1:0]   count_reg;

    assign empty = (count_reg == '0);
    assign full  = (count_reg == CW'(DEPTH));
    assign head  = slot_reg[rd_ptr_reg];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= (wr_ptr_reg == PW'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
            end
            if (pop)
            begin
                rd_ptr_reg <= (rd_ptr_reg == PW'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
            end
            case ({push, pop})
                2'b10:   count_reg <= count_reg + 1'b1;
                2'b01:   count_reg <= count_reg - 1'b1;
                default: count_reg <= count_reg;
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slot_reg[wr_ptr_reg] <= push_entry;
        end
    end

    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        push |-> !full)
        else $error("queue overflow");

    a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
        pop |-> !empty)
        else $error("queue underflow");

endmodule

### rtl/cbd_back.sv
`timescale 1ns / 1ps

module cbd_back (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               q_empty,
    input  cbd_pkg::q_entry_t  q_head,
    output logic               pop,
    input  cbd_pkg::palette_t  palette,
    output logic               dst_valid,
    input  logic               dst_stall,
    output cbd_pkg::dst_word_t dst_word
);

    import cbd_pkg::*;

    typedef enum logic [1:0] {
        B_IDLE,
        B_VERT,
        B_PAL,
        B_DONE
    } state_t;

    state_t      state_reg;
    kind_t       kind_reg;
    logic [6:0]  dx_reg, dy_reg;
    logic [31:0] top_reg, bot_reg;
    logic [6:0]  stop_reg, sbot_reg;
    logic [6:0]  fp_reg;
    logic [15:0] res_reg;
    logic        out_valid_reg;
    dst_word_t   dst_word_reg;

    logic [4:0]  wx_head, wy;
    logic [5:0]  wxc_head, wyc;
    logic [31:0] top_mix, bot_mix;
    logic [7:0]  stop_sum, sbot_sum;
    logic [15:0] vert_rgb;
    logic [11:0] fp_sum;
    logic [1:0]  lo, hi;
    logic [15:0] pal_mix;
    logic        load_out;

    assign pop      = (state_reg == B_IDLE) && !q_empty;
    assign load_out = (state_reg == B_DONE) && (!out_valid_reg || !dst_stall);

    // horizontal pass, straight from the queue head
    assign wx_head  = COL_WEIGHT[q_head.dx[1:0]];
    assign wxc_head = WEIGHT_ONE - {1'b0, wx_head};
    assign top_mix  = mix565(spread565(q_head.ul_color), spread565(q_head.up_color), wx_head);
    assign bot_mix  = mix565(spread565(q_head.left_color), spread565(q_head.color), wx_head);
    assign stop_sum = 8'(q_head.ul_shade) * 8'(wxc_head)
                    + 8'(q_head.up_shade) * 8'({1'b0, wx_head});
    assign sbot_sum = 8'(q_head.left_shade) * 8'(wxc_head)
                    + 8'(q_head.shade) * 8'({1'b0, wx_head});

    // vertical pass
    assign wy       = ROW_WEIGHT[dy_reg[2:0]];
    assign wyc      = WEIGHT_ONE - {1'b0, wy};
    assign vert_rgb = pack565(mix565(top_reg, bot_reg, wy));
    assign fp_sum   = 12'(stop_reg) * 12'(wyc) + 12'(sbot_reg) * 12'({1'b0, wy});

    // palette lerp between the two bracketing shades, upper one clamped
    assign lo      = fp_reg[6:5];
    assign hi      = (lo == 2'd3) ? 2'd3 : lo + 2'd1;
    assign pal_mix = pack565(mix565(spread565(palette[lo]), spread565(palette[hi]),
                                    fp_reg[4:0]));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= B_IDLE;
            out_valid_reg <= 1'b0;
            kind_reg      <= KIND_PASS;
            dx_reg        <= '0;
            dy_reg        <= '0;
            top_reg       <= '0;
            bot_reg       <= '0;
            stop_reg      <= '0;
            sbot_reg      <= '0;
            fp_reg        <= '0;
            res_reg       <= '0;
            dst_word_reg  <= '0;
        end
        else
        begin
            if (load_out)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (!dst_stall)
            begin
                out_valid_reg <= 1'b0;
            end

            unique case (state_reg)
                B_IDLE:
                begin
                    if (!q_empty)
                    begin
                        kind_reg  <= q_head.kind;
                        dx_reg    <= q_head.dx;
                        dy_reg    <= q_head.dy;
                        top_reg   <= top_mix;
                        bot_reg   <= bot_mix;
                        stop_reg  <= stop_sum[6:0];
                        sbot_reg  <= sbot_sum[6:0];
                        res_reg   <= q_head.color;
                        state_reg <= (q_head.kind == KIND_PASS) ? B_DONE : B_VERT;
                    end
                end
                B_VERT:
                begin
                    res_reg   <= vert_rgb;
                    fp_reg    <= fp_sum[11:5];
                    state_reg <= (kind_reg == KIND_PAL) ? B_PAL : B_DONE;
                end
                B_PAL:
                begin
                    res_reg   <= pal_mix;
                    state_reg <= B_DONE;
                end
                B_DONE:
                begin
                    // hold the result until the output register frees up
                    if (load_out)
                    begin
                        dst_word_reg.pixel     <= res_reg;
                        dst_word_reg.out_x     <= dx_reg;
                        dst_word_reg.out_y     <= dy_reg;
                        dst_word_reg.frame_end <= (dx_reg == 7'(OUTPUT_SIZE - 1))
                                               && (dy_reg == 7'(OUTPUT_SIZE - 1));
                        state_reg              <= B_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= B_IDLE;
                end
            endcase
        end
    end

    assign dst_valid = out_valid_reg;
    assign dst_word  = dst_word_reg;

    a_pop_leaves_idle: assert property (@(posedge clk) disable iff (!rst_n)
        pop |=> (state_reg != B_IDLE))
        else $error("back end popped without starting work");

    a_pal_step_kind: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == B_PAL) |-> (kind_reg == KIND_PAL))
        else $error("palette step entered for a non-palette word");

endmodule

### rtl/coverage_blend_downscaler.sv
`timescale 1ns / 1ps

// Downscales a 160x144 RGB565 source frame to 128x128 output pixels.
// Source channel: src_valid/src_stall/src_word, one source pixel with its shade
// index per word, in raster order; frame_start on the first pixel of a frame.
// Result channel: dst_valid/dst_stall/dst_word, one output pixel with its
// column and row; frame_end on pixel (127,127). Source pixels that complete no
// output pixel give no result word.
// Configuration: APB-style port, registers at byte address 4*i in the order
// mode, window_x, window_y, palette shades 0..3; write only while idle.
// The front end takes a new source word only after the line buffer read and
// write-back of the last one. The back end steps each word through idle and
// done in nearest and crop modes, adds a vertical step in rgb blend and then
// a palette step in palette blend; a queue of QUEUE_DEPTH words between them
// absorbs the difference. With an empty queue and a free output, a word
// passes the capture registers, queue, back end states and output register.
// A stalled result sits in the output register; the back end and queue keep
// filling behind it, and src_stall rises once the queue is full.
// Reset clears the position counters and neighbor registers and loads the
// register defaults; the line buffer is not cleared.
module coverage_blend_downscaler #(
    parameter int QUEUE_DEPTH = 4
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        src_valid,
    output logic                        src_stall,
    input  cbd_pkg::src_word_t          src_word,
    output logic                        dst_valid,
    input  logic                        dst_stall,
    output cbd_pkg::dst_word_t          dst_word,
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [cbd_pkg::PADDR_W-1:0] paddr,
    input  logic [31:0]                 pwdata,
    output logic [31:0]                 prdata,
    output logic                        pready
);

    import cbd_pkg::*;

    mode_t      mode_reg;
    logic [5:0] window_x_reg;
    logic [4:0] window_y_reg;
    palette_t   palette_reg;
    reg_idx_t   reg_idx;
    logic       cfg_write;
    cfg_t       cfg;

    logic     push, pop, q_empty, q_full;
    q_entry_t push_entry, q_head;

    assign pready    = 1'b1;
    assign cfg_write = psel & penable & pwrite & pready;
    assign reg_idx   = reg_idx_t'(paddr[PADDR_W-1:2]);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg     <= MODE_RGB;
            window_x_reg <= 6'd16;
            window_y_reg <= 5'd8;
            palette_reg  <= '0;
        end
        else if (cfg_write)
        begin
            unique case (reg_idx)
                REG_MODE:     mode_reg       <= mode_t'(pwdata[1:0]);
                REG_WINDOW_X: window_x_reg   <= pwdata[5:0];
                REG_WINDOW_Y: window_y_reg   <= pwdata[4:0];
                REG_SHADE0:   palette_reg[0] <= pwdata[15:0];
                REG_SHADE1:   palette_reg[1] <= pwdata[15:0];
                REG_SHADE2:   palette_reg[2] <= pwdata[15:0];
                REG_SHADE3:   palette_reg[3] <= pwdata[15:0];
                default:      ;
            endcase
        end
    end

    always_comb
    begin
        unique case (reg_idx)
            REG_MODE:     prdata = {30'd0, mode_reg};
            REG_WINDOW_X: prdata = {26'd0, window_x_reg};
            REG_WINDOW_Y: prdata = {27'd0, window_y_reg};
            REG_SHADE0:   prdata = {16'd0, palette_reg[0]};
            REG_SHADE1:   prdata = {16'd0, palette_reg[1]};
            REG_SHADE2:   prdata = {16'd0, palette_reg[2]};
            REG_SHADE3:   prdata = {16'd0, palette_reg[3]};
            default:      prdata = '0;
        endcase
    end

    always_comb
    begin
        cfg.mode     = mode_reg;
        cfg.window_x = window_x_reg;
        cfg.window_y = window_y_reg;
    end

    cbd_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .src_valid  (src_valid),
        .src_stall  (src_stall),
        .src_word   (src_word),
        .cfg        (cfg),
        .q_full     (q_full),
        .push       (push),
        .push_entry (push_entry)
    );

    cbd_queue #(
        .DEPTH(QUEUE_DEPTH)
    ) u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .push_entry (push_entry),
        .pop        (pop),
        .head       (q_head),
        .empty      (q_empty),
        .full       (q_full)
    );

    cbd_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .q_empty   (q_empty),
        .q_head    (q_head),
        .pop       (pop),
        .palette   (palette_reg),
        .dst_valid (dst_valid),
        .dst_stall (dst_stall),
        .dst_word  (dst_word)
    );

endmodule

### tb/sv/tb.sv
`timescale 1ns / 1ps

module tb;

    import cbd_pkg::*;

    localparam logic [31:0] CHANNEL_MASK = 32'h07E0_F81F;

    class downscale_check;
        mode_t       mode;
        logic [5:0]  win_x;
        logic [4:0]  win_y;
        logic [15:0] shade_rgb[4];
        logic [15:0] line_color[SOURCE_WIDTH];
        logic [1:0]  line_shade[SOURCE_WIDTH];
        logic [15:0] left_color;
        logic [15:0] ul_color;
        logic [1:0]  left_shade;
        logic [1:0]  ul_shade;
        int unsigned col;
        int unsigned row;
        int unsigned hweight[4];
        int unsigned vweight[8];
        dst_word_t   pending_pixels[$];
        int          mismatch_count;
        int          pixels_checked;
        int          frame_ends;

        function new();
            mode = MODE_RGB;
            win_x = 6'd16;
            win_y = 5'd8;
            foreach (shade_rgb[i]) shade_rgb[i] = '0;
            foreach (line_color[i])
            begin
                line_color[i] = '0;
                line_shade[i] = '0;
            end
            left_color = '0;
            ul_color = '0;
            left_shade = '0;
            ul_shade = '0;
            col = 0;
            row = 0;
            hweight = '{6, 13, 19, 26};
            vweight = '{4, 7, 11, 14, 18, 21, 25, 28};
            mismatch_count = 0;
            pixels_checked = 0;
            frame_ends = 0;
        endfunction

        function void set_register(reg_idx_t idx, logic [31:0] v);
            case (idx)
                REG_MODE:     mode = mode_t'(v[1:0]);
                REG_WINDOW_X: win_x = v[5:0];
                REG_WINDOW_Y: win_y = v[4:0];
                REG_SHADE0:   shade_rgb[0] = v[15:0];
                REG_SHADE1:   shade_rgb[1] = v[15:0];
                REG_SHADE2:   shade_rgb[2] = v[15:0];
                REG_SHADE3:   shade_rgb[3] = v[15:0];
                default: ;
            endcase
        endfunction

        function logic [31:0] register_value(reg_idx_t idx);
            case (idx)
                REG_MODE:     return {30'd0, mode};
                REG_WINDOW_X: return {26'd0, win_x};
                REG_WINDOW_Y: return {27'd0, win_y};
                REG_SHADE0:   return {16'd0, shade_rgb[0]};
                REG_SHADE1:   return {16'd0, shade_rgb[1]};
                REG_SHADE2:   return {16'd0, shade_rgb[2]};
                REG_SHADE3:   return {16'd0, shade_rgb[3]};
                default:      return '0;
            endcase
        endfunction

        function bit [31:0] spread_channels(logic [15:0] p);
            return {p, p} & CHANNEL_MASK;
        endfunction

        function bit [31:0] lerp_channels(bit [31:0] a, bit [31:0] b, int unsigned w);
            bit [31:0] d;
            bit [31:0] p;
            d = b - a;
            p = d * w;
            return (a + (p >> 5)) & CHANNEL_MASK;
        endfunction

        function bit [15:0] fold_channels(bit [31:0] c);
            return c[15:0] | c[31:16];
        endfunction

        function int out_col(int unsigned s);
            int unsigned d;
            d = (s * 4 + 4) / 5;
            if (d >= OUTPUT_SIZE || (d * 5) / 4 != s) return -1;
            return d;
        endfunction

        function int out_row(int unsigned s);
            int unsigned d;
            d = (s * 8 + 8) / 9;
            if (d >= OUTPUT_SIZE || (d * 9) / 8 != s) return -1;
            return d;
        endfunction

        // advance the frame position by one word and queue the pixel it completes
        function void take_source(src_word_t w);
            int unsigned c;
            int unsigned r;
            int unsigned wx;
            int unsigned wy;
            int unsigned top;
            int unsigned bot;
            int unsigned fp;
            int unsigned lo;
            int unsigned hi;
            logic [15:0] up_c;
            logic [1:0]  up_s;
            bit [31:0]   pix;
            bit [31:0]   t;
            bit [31:0]   b;
            int          dx;
            int          dy;
            dst_word_t   res;
            pix = '0;
            dx = -1;
            dy = -1;
            if (w.frame_start)
            begin
                col = 0;
                row = 0;
            end
            c = (col >= SOURCE_WIDTH) ? 0 : col;
            r = row;
            up_c = line_color[c];
            up_s = line_shade[c];
            case (mode)
                MODE_NEAREST:
                begin
                    dx = out_col(c);
                    dy = out_row(r);
                    pix = w.color;
                end
                MODE_CROP:
                begin
                    wx = (win_x > 32) ? 32 : win_x;
                    wy = (win_y > 16) ? 16 : win_y;
                    if (c >= wx && c < wx + OUTPUT_SIZE) dx = c - wx;
                    if (r >= wy && r < wy + OUTPUT_SIZE) dy = r - wy;
                    pix = w.color;
                end
                default:
                begin
                    if (c >= 1 && r >= 1)
                    begin
                        dx = out_col(c - 1);
                        dy = out_row(r - 1);
                    end
                    if (dx >= 0 && dy >= 0)
                    begin
                        wx = hweight[dx & 3];
                        wy = vweight[dy & 7];
                        if (mode == MODE_RGB)
                        begin
                            t = lerp_channels(spread_channels(ul_color),
                                              spread_channels(up_c), wx);
                            b = lerp_channels(spread_channels(left_color),
                                              spread_channels(w.color), wx);
                            pix = fold_channels(lerp_channels(t, b, wy));
                        end
                        else
                        begin
                            top = ul_shade * (32 - wx) + up_s * wx;
                            bot = left_shade * (32 - wx) + w.shade * wx;
                            fp = (top * (32 - wy) + bot * wy) >> 5;
                            lo = (fp >> 5) & 3;
                            hi = (lo == 3) ? 3 : lo + 1;
                            pix = fold_channels(lerp_channels(spread_channels(shade_rgb[lo]),
                                                              spread_channels(shade_rgb[hi]),
                                                              fp & 31));
                        end
                    end
                end
            endcase
            ul_color = up_c;
            ul_shade = up_s;
            line_color[c] = w.color;
            line_shade[c] = w.shade;
            left_color = w.color;
            left_shade = w.shade;
            if (c + 1 >= SOURCE_WIDTH)
            begin
                col = 0;
                row = (r < 255) ? r + 1 : 255;
            end
            else
            begin
                col = c + 1;
                row = r;
            end
            if (dx >= 0 && dy >= 0)
            begin
                res.pixel = pix[15:0];
                res.out_x = 7'(dx);
                res.out_y = 7'(dy);
                res.frame_end = (dx == OUTPUT_SIZE - 1) && (dy == OUTPUT_SIZE - 1);
                pending_pixels.push_back(res);
            end
        endfunction

        task report_mismatch(string msg);
            if (mismatch_count < 40) $display("MISMATCH at %0t: %s", $time, msg);
            mismatch_count++;
        endtask

        task check_pixel(dst_word_t got);
            dst_word_t want;
            if (pending_pixels.size() == 0)
            begin
                report_mismatch($sformatf("unexpected pixel %h at (%0d,%0d)",
                                          got.pixel, got.out_x, got.out_y));
                return;
            end
            want = pending_pixels.pop_front();
            pixels_checked++;
            if (got.frame_end === 1'b1) frame_ends++;
            if (got.pixel !== want.pixel)
                report_mismatch($sformatf("pixel %h, want %h at (%0d,%0d)",
                                          got.pixel, want.pixel, want.out_x, want.out_y));
            if (got.out_x !== want.out_x)
                report_mismatch($sformatf("out_x %0d, want %0d", got.out_x, want.out_x));
            if (got.out_y !== want.out_y)
                report_mismatch($sformatf("out_y %0d, want %0d", got.out_y, want.out_y));
            if (got.frame_end !== want.frame_end)
                report_mismatch($sformatf("frame_end %b, want %b at (%0d,%0d)",
                                          got.frame_end, want.frame_end,
                                          want.out_x, want.out_y));
        endtask
    endclass

    logic                 clk;
    logic                 rst_n     = 1'b0;
    logic                 src_valid = 1'b0;
    logic                 src_stall;
    src_word_t            src_word  = '0;
    logic                 dst_valid;
    logic                 dst_stall = 1'b0;
    dst_word_t            dst_word;
    logic                 psel      = 1'b0;
    logic                 penable   = 1'b0;
    logic                 pwrite    = 1'b0;
    logic [PADDR_W-1:0]   paddr     = '0;
    logic [31:0]          pwdata    = '0;
    logic [31:0]          prdata;
    logic                 pready;

    downscale_check sb;
    int             tx_idle_pct  = 0;
    int             rx_stall_pct = 0;
    int             source_words = 0;

    coverage_blend_downscaler u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .src_valid (src_valid),
        .src_stall (src_stall),
        .src_word  (src_word),
        .dst_valid (dst_valid),
        .dst_stall (dst_stall),
        .dst_word  (dst_word),
        .psel      (psel),
        .penable   (penable),
        .pwrite    (pwrite),
        .paddr     (paddr),
        .pwdata    (pwdata),
        .prdata    (prdata),
        .pready    (pready)
    );

    always
    begin
        clk = 1'b0;
        #6;
        clk = 1'b1;
        #6;
    end

    always @(negedge clk)
    begin
        dst_stall <= ($urandom_range(99) < rx_stall_pct);
    end

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (src_valid && !src_stall)
            begin
                sb.take_source(src_word);
                source_words++;
            end
            if (dst_valid && !dst_stall) sb.check_pixel(dst_word);
        end
    end

    // one APB transfer; starts and returns at a falling edge
    task automatic apb_cycle(input reg_idx_t idx, input bit wr, input logic [31:0] wdata,
                             output logic [31:0] rdata);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= wr;
        paddr <= {idx, 2'b00};
        pwdata <= wdata;
        @(negedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready) @(posedge clk);
        rdata = prdata;
        if (wr) sb.set_register(idx, wdata);
        @(negedge clk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        @(negedge clk);
    endtask

    task automatic read_check(input reg_idx_t idx);
        logic [31:0] rd;
        apb_cycle(idx, 1'b0, '0, rd);
        if (rd !== sb.register_value(idx))
            sb.report_mismatch($sformatf("%s reads %h, want %h",
                                         idx.name(), rd, sb.register_value(idx)));
    endtask

    task automatic write_reg(input reg_idx_t idx, input logic [31:0] v);
        logic [31:0] unused;
        apb_cycle(idx, 1'b1, v, unused);
        read_check(idx);
    endtask

    task automatic configure(input mode_t m, input logic [5:0] wx, input logic [4:0] wy,
                             input logic [15:0] p0, input logic [15:0] p1,
                             input logic [15:0] p2, input logic [15:0] p3);
        write_reg(REG_MODE, {30'd0, m});
        write_reg(REG_WINDOW_X, {26'd0, wx});
        write_reg(REG_WINDOW_Y, {27'd0, wy});
        write_reg(REG_SHADE0, {16'd0, p0});
        write_reg(REG_SHADE1, {16'd0, p1});
        write_reg(REG_SHADE2, {16'd0, p2});
        write_reg(REG_SHADE3, {16'd0, p3});
    endtask

    task automatic set_idling(input int phase);
        case (phase)
            0:
            begin
                tx_idle_pct = 0;
                rx_stall_pct = 0;
            end
            1:
            begin
                tx_idle_pct = 46;
                rx_stall_pct = 0;
            end
            2:
            begin
                tx_idle_pct = 0;
                rx_stall_pct = 46;
            end
            default:
            begin
                tx_idle_pct = 18;
                rx_stall_pct = 18;
            end
        endcase
    endtask

    // present one word and hold it until taken; called at a falling edge
    task automatic send_fields(input logic [15:0] color, input logic [1:0] shade,
                               input logic fs);
        while ($urandom_range(99) < tx_idle_pct)
        begin
            src_valid <= 1'b0;
            @(negedge clk);
        end
        src_valid <= 1'b1;
        src_word <= '{color: color, shade: shade, frame_start: fs};
        @(posedge clk);
        while (src_stall) @(posedge clk);
        @(negedge clk);
    endtask

    task automatic stream_frame(input int unsigned count, input bit restart,
                                input int unsigned noise_rate);
        logic [15:0] color;
        logic        fs;
        for (int unsigned i = 0; i < count; i++)
        begin
            color = 16'($urandom);
            // bias toward the channel extremes now and then
            if ($urandom_range(7) == 0) color = $urandom_range(1) ? 16'hFFFF : 16'h0000;
            fs = (i == 0 && restart) ||
                 (noise_rate != 0 && $urandom_range(noise_rate - 1) == 0);
            send_fields(color, 2'($urandom_range(3)), fs);
        end
    endtask

    task automatic wait_drained();
        src_valid <= 1'b0;
        @(negedge clk);
        while (sb.pending_pixels.size() != 0) @(negedge clk);
        // a word that completes no pixel may still be in flight
        repeat (16) @(negedge clk);
    endtask

    initial
    begin
        #5_000_000;
        $display("timeout: block stopped making progress");
        $display("end of test: mismatches");
        $finish;
    end

    initial
    begin
        reg_idx_t ri;
        mode_t    m;
        bit       blend;
        sb = new();
        repeat (12) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        ri = ri.first();
        repeat (ri.num())
        begin
            read_check(ri);
            ri = ri.next();
        end

        // blend modes give nothing on the top row
        send_fields(16'hFFFF, 2'd3, 1'b1);
        send_fields(16'h0000, 2'd0, 1'b0);
        send_fields(16'hFFFF, 2'd1, 1'b0);
        send_fields(16'h0000, 2'd2, 1'b0);

        wait_drained();
        configure(MODE_NEAREST, 6'd32, 5'd16, 16'h0000, 16'h0000, 16'h0000, 16'h0000);
        send_fields(16'hFFFF, 2'd3, 1'b1);
        for (int i = 0; i < 8; i++)
            send_fields(i[0] ? 16'hFFFF : 16'h0000, 2'(i), 1'b0);
        // restart mid-frame; the line buffer keeps its contents
        send_fields(16'h8421, 2'd2, 1'b1);
        send_fields(16'h7BDE, 2'd1, 1'b0);

        wait_drained();
        configure(MODE_CROP, 6'd0, 5'd0, 16'hFFFF, 16'h0000, 16'hFFFF, 16'h0000);
        send_fields(16'h0000, 2'd0, 1'b1);
        send_fields(16'hFFFF, 2'd3, 1'b0);
        send_fields(16'hF800, 2'd1, 1'b0);
        send_fields(16'h001F, 2'd2, 1'b0);

        // short frames with random content, one mode per idling phase;
        // blend runs reach the second source row so that they produce pixels
        m = m.first();
        for (int p = 0; p < 4; p++)
        begin
            wait_drained();
            set_idling(p);
            blend = (m == MODE_RGB) || (m == MODE_PALETTE);
            configure(m, (m == MODE_NEAREST) ? 6'd32 : 6'($urandom_range(40)),
                      (m == MODE_NEAREST) ? 5'd16 : 5'd0,
                      16'($urandom), 16'($urandom), 16'($urandom), 16'($urandom));
            stream_frame(blend ? 220 : 130,
                         (p == 0) || blend || ($urandom_range(1) == 1),
                         blend ? 0 : 64);
            m = m.next();
        end

        wait_drained();
        $display("drove %0d source words through nearest, rgb blend, palette blend and crop",
                 source_words);
        $display("compared %0d output pixels, saw %0d frame ends",
                 sb.pixels_checked, sb.frame_ends);
        if (sb.mismatch_count == 0 && sb.pending_pixels.size() == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end

endmodule

### filelist.f
rtl/cbd_pkg.sv
rtl/cbd_ram.sv
rtl/cbd_front.sv
rtl/cbd_queue.sv
rtl/cbd_back.sv
rtl/coverage_blend_downscaler.sv
tb/sv/tb.sv
